// ----- rtl/plst_pkg.sv -----
`default_nettype none
package plst_pkg;

  localparam int DATA_W       = 32;
  localparam int MODE_W       = 3;
  localparam int POS_W        = 5;
  localparam int CNT_OUT_W    = 5;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT  = 3'd0,
    MODE_INS_BACK   = 3'd1,
    MODE_INS_AT     = 3'd2,
    MODE_DROP_FRONT = 3'd3,
    MODE_DROP_BACK  = 3'd4,
    MODE_READ_AT    = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DROP   = 2'd2
  } cell_op_t;

  typedef enum logic {
    S_IDLE    = 1'b0,
    S_COLLECT = 1'b1
  } state_t;

  typedef struct packed {
    cell_op_t op;
    logic     rd_en;
    logic     last_en;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/positional_list_store_core.sv -----
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells, one entry per
// cell, packed from the front. For each request, on the accepting edge every cell shifts, loads
// or holds at once, and then, in the collect state, the cells drive the read and back entries
// onto the result register. in_ready is low during the collect state; the result register
// frees the input, so one further request is taken while a finished result waits, and the
// collect state of that request stretches until out_ready takes the waiting result. A new
// request is not taken before the last has loaded its result; each gives exactly one result.
module positional_list_store_core #(
  parameter int CAPACITY = plst_pkg::DEF_CAPACITY
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire         [plst_pkg::MODE_W-1:0]    mode,
  input  wire         [plst_pkg::POS_W-1:0]     position,
  input  wire  signed [plst_pkg::DATA_W-1:0]    value,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [plst_pkg::DATA_W-1:0]    read_value,
  output logic signed [plst_pkg::DATA_W-1:0]    first_value,
  output logic signed [plst_pkg::DATA_W-1:0]    last_value,
  output logic        [plst_pkg::CNT_OUT_W-1:0] entry_count,
  output logic                                  is_empty,
  output logic        [plst_pkg::STATUS_W-1:0]  status
);
  import plst_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_ctl_t         ctl;
  logic [IDX_W-1:0]  ins_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  last_idx;
  logic              res_load;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] rd_tap    [CAPACITY];
  logic [DATA_W-1:0] last_tap  [CAPACITY];
  logic [DATA_W-1:0] rd_sum;
  logic [DATA_W-1:0] last_sum;

  plst_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ctl         (ctl),
    .ins_idx     (ins_idx),
    .rd_idx      (rd_idx),
    .last_idx    (last_idx),
    .res_load    (res_load),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .status      (status)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_d;
    logic [DATA_W-1:0] next_d;

    if (i == 0) begin : g_head
      assign prev_d = value;
    end else begin : g_body
      assign prev_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_d = cell_data[i];
    end else begin : g_mid
      assign next_d = cell_data[i+1];
    end

    plst_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .ins_idx   (ins_idx),
      .rd_idx    (rd_idx),
      .last_idx  (last_idx),
      .value     (value),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i]),
      .rd_tap    (rd_tap[i]),
      .last_tap  (last_tap[i])
    );
  end

  always_comb begin
    rd_sum   = '0;
    last_sum = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_sum   = rd_sum | rd_tap[k];
      last_sum = last_sum | last_tap[k];
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      read_value  <= rd_sum;
      last_value  <= last_sum;
      first_value <= ctl.last_en ? cell_data[0] : '0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/plst_cell.sv -----
`default_nettype none
module plst_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  wire                          clk,
  input  wire  plst_pkg::cell_ctl_t    ctl,
  input  wire  [IDX_W-1:0]             ins_idx,
  input  wire  [IDX_W-1:0]             rd_idx,
  input  wire  [IDX_W-1:0]             last_idx,
  input  wire  [plst_pkg::DATA_W-1:0]  value,
  input  wire  [plst_pkg::DATA_W-1:0]  prev_data,
  input  wire  [plst_pkg::DATA_W-1:0]  next_data,
  output logic [plst_pkg::DATA_W-1:0]  data,
  output logic [plst_pkg::DATA_W-1:0]  rd_tap,
  output logic [plst_pkg::DATA_W-1:0]  last_tap
);
  import plst_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INSERT: begin
        if (MY_IDX > ins_idx) begin
          data <= prev_data;
        end else if (MY_IDX == ins_idx) begin
          data <= value;
        end
      end
      OP_DROP: begin
        data <= next_data;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rd_tap   = (ctl.rd_en && rd_idx == MY_IDX) ? data : '0;
    last_tap = (ctl.last_en && last_idx == MY_IDX) ? data : '0;
  end

endmodule
`default_nettype wire

// ----- rtl/plst_ctrl.sv -----
`default_nettype none
module plst_ctrl #(
  parameter int CAPACITY = 16,
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [plst_pkg::MODE_W-1:0]     mode,
  input  wire  [plst_pkg::POS_W-1:0]      position,
  output logic                            out_valid,
  input  wire                             out_ready,
  output plst_pkg::cell_ctl_t             ctl,
  output logic [IDX_W-1:0]                ins_idx,
  output logic [IDX_W-1:0]                rd_idx,
  output logic [IDX_W-1:0]                last_idx,
  output logic                            res_load,
  output logic [plst_pkg::CNT_OUT_W-1:0]  entry_count,
  output logic                            is_empty,
  output logic [plst_pkg::STATUS_W-1:0]   status
);
  import plst_pkg::*;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             rd_en;
  logic             last_en;
  status_t          status_q;
  status_t          st_new;
  cell_op_t         op_new;
  logic             rd_ok;
  logic             accept;
  logic             full;
  logic             empty;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;

  always_comb begin
    in_ready   = (state == S_IDLE);
    accept     = in_valid && in_ready;
    res_load   = (state == S_COLLECT) && (!out_valid || out_ready);
    full       = (count == CNT_W'(CAPACITY));
    empty      = (count == '0);
    pos_x      = CMP_W'(position);
    cnt_x      = CMP_W'(count);
    st_new     = ST_OK;
    op_new     = OP_HOLD;
    count_next = count;
    ins_idx    = '0;
    rd_ok      = 1'b0;
    state_next = state;

    case (mode)
      MODE_INS_FRONT: begin
        if (full) begin
          st_new = ST_FULL;
        end else begin
          op_new     = OP_INSERT;
          count_next = count + 1'b1;
        end
      end
      MODE_INS_BACK: begin
        ins_idx = IDX_W'(count);
        if (full) begin
          st_new = ST_FULL;
        end else begin
          op_new     = OP_INSERT;
          count_next = count + 1'b1;
        end
      end
      MODE_INS_AT: begin
        ins_idx = IDX_W'(pos_x);
        if (pos_x > cnt_x) begin
          st_new = ST_BADPOS;
        end else if (full) begin
          st_new = ST_FULL;
        end else begin
          op_new     = OP_INSERT;
          count_next = count + 1'b1;
        end
      end
      MODE_DROP_FRONT: begin
        if (empty) begin
          st_new = ST_EMPTY;
        end else begin
          op_new     = OP_DROP;
          count_next = count - 1'b1;
        end
      end
      MODE_DROP_BACK: begin
        if (empty) begin
          st_new = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      MODE_READ_AT: begin
        if (pos_x >= cnt_x) begin
          st_new = ST_BADPOS;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (!accept) begin
      op_new     = OP_HOLD;
      count_next = count;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_COLLECT;
        end
      end
      S_COLLECT: begin
        if (res_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    ctl.op      = op_new;
    ctl.rd_en   = rd_en;
    ctl.last_en = last_en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx   <= IDX_W'(pos_x);
      rd_en    <= rd_ok;
      last_idx <= IDX_W'(count_next - 1'b1);
      last_en  <= (count_next != '0);
      status_q <= st_new;
    end
    if (res_load) begin
      status      <= status_q;
      entry_count <= CNT_OUT_W'(count);
      is_empty    <= (count == '0);
    end
  end

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import plst_pkg::*;

  localparam int LIST_DEPTH = DEF_CAPACITY;
  localparam int RUN_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLDOFF_CYCLES = 150;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
  } list_request_t;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic signed [DATA_W-1:0] first_value;
    logic signed [DATA_W-1:0] last_value;
    logic [CNT_OUT_W-1:0]     entry_count;
    logic                     is_empty;
    logic [STATUS_W-1:0]      status;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] mode = '0;
  logic [POS_W-1:0] position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] read_value;
  logic signed [DATA_W-1:0] first_value;
  logic signed [DATA_W-1:0] last_value;
  logic [CNT_OUT_W-1:0] entry_count;
  logic is_empty;
  logic [STATUS_W-1:0] status;

  list_request_t pending_requests[$];
  list_result_t expected_results[$];
  list_request_t next_request;
  list_result_t seen_result;

  logic signed [DATA_W-1:0] shadow_list[LIST_DEPTH];
  int shadow_len = 0;

  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_pattern = 0;
  int rx_left = 0;
  int hold_left = 0;
  int holds_done = 0;

  positional_list_store_core #(.CAPACITY(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_value(read_value),
    .first_value(first_value),
    .last_value(last_value),
    .entry_count(entry_count),
    .is_empty(is_empty),
    .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void shadow_put(int pos, logic signed [DATA_W-1:0] val);
    int k;
    for (k = shadow_len; k > pos; k--) shadow_list[k] = shadow_list[k-1];
    shadow_list[pos] = val;
    shadow_len++;
  endfunction

  function automatic list_result_t apply_command(list_request_t req);
    list_result_t r;
    int k;
    r = '{default: '0};
    r.status = ST_OK;
    case (req.mode)
      MODE_INS_FRONT: begin
        if (shadow_len >= LIST_DEPTH) r.status = ST_FULL;
        else shadow_put(0, req.val);
      end
      MODE_INS_BACK: begin
        if (shadow_len >= LIST_DEPTH) r.status = ST_FULL;
        else shadow_put(shadow_len, req.val);
      end
      MODE_INS_AT: begin
        if (int'(req.pos) > shadow_len) r.status = ST_BADPOS;
        else if (shadow_len >= LIST_DEPTH) r.status = ST_FULL;
        else shadow_put(int'(req.pos), req.val);
      end
      MODE_DROP_FRONT: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (k = 1; k < shadow_len; k++) shadow_list[k-1] = shadow_list[k];
          shadow_len--;
        end
      end
      MODE_DROP_BACK: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else shadow_len--;
      end
      MODE_READ_AT: begin
        if (int'(req.pos) >= shadow_len) r.status = ST_BADPOS;
        else r.read_value = shadow_list[req.pos];
      end
      default: ;
    endcase
    r.first_value = (shadow_len > 0) ? shadow_list[0] : '0;
    r.last_value = (shadow_len > 0) ? shadow_list[shadow_len-1] : '0;
    r.entry_count = CNT_OUT_W'(shadow_len);
    r.is_empty = (shadow_len == 0);
    return r;
  endfunction

  task automatic queue_request(logic [MODE_W-1:0] m, int p, logic signed [DATA_W-1:0] v);
    list_request_t req;
    req.mode = m;
    req.pos = POS_W'(p);
    req.val = v;
    pending_requests.push_back(req);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_position();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 31);
    return $urandom_range(0, LIST_DEPTH);
  endfunction

  task automatic check_field(string name, logic signed [DATA_W-1:0] exp_v,
                             logic signed [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        next_request = pending_requests.pop_front();
        mode <= next_request.mode;
        position <= next_request.pos;
        value <= next_request.val;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_left == 0) begin
      rx_pattern <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 80);
      if (holds_done == 0 || $urandom_range(0, 9) == 0) begin
        hold_left <= HOLDOFF_CYCLES;
        holds_done <= holds_done + 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end else begin
      rx_left <= rx_left - 1;
      case (rx_pattern)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) != 0);
        2: out_ready <= (rx_left % 3) != 0;
        default: out_ready <= $urandom_range(0, 7) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      expected_results.push_back(apply_command('{mode, position, value}));
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual count %0d status %0d",
                 $time, entry_count, status);
        mismatch_count++;
      end else begin
        seen_result = expected_results.pop_front();
        check_field("read_value", seen_result.read_value, read_value);
        check_field("first_value", seen_result.first_value, first_value);
        check_field("last_value", seen_result.last_value, last_value);
        check_field("entry_count", seen_result.entry_count, entry_count);
        check_field("is_empty", seen_result.is_empty, is_empty);
        check_field("status", seen_result.status, status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int blk;
    int i;
    int r;
    int ins_share;
    int read_share;

    queue_request(MODE_READ_AT, 0, 32'sd5);
    queue_request(MODE_DROP_FRONT, 0, 32'sd0);
    queue_request(MODE_DROP_BACK, 0, 32'sd0);
    queue_request(MODE_INS_AT, 1, 32'sd77);
    queue_request(MODE_INS_AT, 0, 32'sh7fff_ffff);
    queue_request(MODE_DROP_FRONT, 0, 32'sd0);
    queue_request(MODE_INS_BACK, 0, 32'sh8000_0000);
    queue_request(MODE_INS_FRONT, 0, 32'sh7fff_ffff);
    queue_request(MODE_INS_AT, 2, -32'sd1);
    queue_request(MODE_INS_AT, 1, 32'sd0);
    queue_request(MODE_INS_AT, 31, 32'sd9);
    queue_request(MODE_READ_AT, 0, 32'sd0);
    queue_request(MODE_READ_AT, 3, 32'sd0);
    queue_request(MODE_READ_AT, 4, 32'sd0);
    queue_request(MODE_READ_AT, 31, 32'sd0);
    queue_request(MODE_SPARE_LO, 0, 32'sd0);
    queue_request(MODE_SPARE_HI, 31, -32'sd1);
    queue_request(MODE_DROP_BACK, 0, 32'sd0);
    queue_request(MODE_DROP_FRONT, 0, 32'sd0);
    queue_request(MODE_READ_AT, 1, 32'sd0);

    for (blk = 0; blk < 19; blk++) begin
      case (blk % 3)
        0: ins_share = 80;
        1: ins_share = 10;
        default: ins_share = 50;
      endcase
      read_share = $urandom_range(15, 35);
      for (i = 0; i < 50; i++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          queue_request($urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI,
                        $urandom_range(0, 31), $urandom);
        end else if (r < ins_share) begin
          case ($urandom_range(0, 2))
            0: queue_request(MODE_INS_FRONT, $urandom_range(0, 31), pick_value());
            1: queue_request(MODE_INS_BACK, $urandom_range(0, 31), pick_value());
            default: queue_request(MODE_INS_AT, pick_position(), pick_value());
          endcase
        end else if ($urandom_range(0, 99) < read_share) begin
          queue_request(MODE_READ_AT, pick_position(), $urandom);
        end else begin
          queue_request($urandom_range(0, 1) ? MODE_DROP_FRONT : MODE_DROP_BACK,
                        $urandom_range(0, 31), $urandom);
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
